@@ hdl/ray_box_slab_intersect_assert.svh @@
// Assertion helpers for ray_box_slab_intersect.sv.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define RBSI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbsi assertion failed");

// Next-cycle implication, switched off during reset.
`define RBSI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbsi assertion failed");

`endif

@@ hdl/rbsi_pkg.sv @@
`timescale 1ns / 1ps
package rbsi_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int DIR_WIDTH       = 32;
    localparam int DIR_FRAC        = 30;
    localparam int QUO_WIDTH       = COORD_WIDTH - 1;
    localparam int DIV_STAGES      = QUO_WIDTH + 1;
    localparam int DIV_REM_WIDTH   = COORD_WIDTH + DIR_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_X = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_Y = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_Z = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_X    = CFG_INDEX_WIDTH'(3);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_Y    = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_Z    = CFG_INDEX_WIDTH'(5);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } box_t;

    typedef struct packed {
        logic                   hit;
        logic [COORD_WIDTH-2:0] distance;
        coord_t                 point_x;
        coord_t                 point_y;
        coord_t                 point_z;
        logic [1:0]             normal_axis;
        logic                   normal_negative;
    } result_t;

endpackage

@@ hdl/rbsi_div.sv @@
`timescale 1ns / 1ps
module rbsi_div
    import rbsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH:0]   num,
    input  logic [DIR_WIDTH-1:0]   den,
    output logic [QUO_WIDTH-1:0]   quo
);

    localparam int WR = DIV_REM_WIDTH;

    logic [WR-1:0]        rem_reg [DIV_STAGES];
    logic [DIR_WIDTH-1:0] den_reg [DIV_STAGES];
    logic [QUO_WIDTH-1:0] quo_reg [DIV_STAGES];
    logic                 sat_reg [DIV_STAGES];

    logic [WR-1:0] rem_next;
    logic          sat_next;

    // The quotient is saturated when it would need more bits than the result holds.
    always_comb
    begin
        rem_next = WR'(num) << DIR_FRAC;
        sat_next = rem_next >= (WR'(den) << QUO_WIDTH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_step
        logic [WR-1:0]        trial;
        logic [WR-1:0]        step_rem_next;
        logic [QUO_WIDTH-1:0] step_quo_next;

        always_comb
        begin
            trial = WR'(den_reg[k-1]) << (QUO_WIDTH - k);
            if (rem_reg[k-1] >= trial)
            begin
                step_rem_next = rem_reg[k-1] - trial;
                step_quo_next = quo_reg[k-1] | (QUO_WIDTH'(1) << (QUO_WIDTH - k));
            end
            else
            begin
                step_rem_next = rem_reg[k-1];
                step_quo_next = quo_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= step_rem_next;
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= step_quo_next;
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quo = sat_reg[DIV_STAGES-1] ? '1 : quo_reg[DIV_STAGES-1];

endmodule

@@ hdl/ray_box_slab_intersect.sv @@
// Ray against axis-aligned box slab test. The ray origin (Q16.16) and unit direction (Q2.30)
// sit in configuration registers; the user must write them only while the block is idle, as
// the block itself does not enforce it. Each input beat carries one box and yields exactly
// one result beat with hit flag, saturated distance, hit point and face normal. One box is
// taken every clock cycle while in_stall is low. Each box passes through the six
// slab dividers, which retire one quotient bit per pipeline stage, followed by seven stages
// for slab combining, hit point multiply and the cross-multiplied normal compare. An
// output register with a one-beat skid buffer lets the pipeline keep taking boxes while a
// result waits; the input stalls only once that buffer is full.
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_assert.svh"
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  box_t                       in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output result_t                    out_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int DIFF_W = CW + 1;
    localparam int PROD_W = DIR_WIDTH + QUO_WIDTH;
    localparam int SUM_W  = CW + 3;
    localparam int NUM_W  = CW + 2;
    localparam int DEN_W  = CW + 1;
    localparam int XP_W   = NUM_W + DEN_W;
    localparam int NSTAGES = DIV_STAGES + 8;

    localparam logic [CW-1:0]        TMAX_C  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        NTMAX_C = {1'b1, {(CW-2){1'b0}}, 1'b1};
    localparam logic [CW-1:0]        CMIN_C  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [DIR_WIDTH-1:0] DIR_ONE = DIR_WIDTH'(1) << DIR_FRAC;

    typedef struct packed {
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
    } box_side_t;

    typedef struct packed {
        box_side_t  bx;
        logic [2:0] dzero;
        logic       zmiss;
        logic [2:0] neg_lo;
        logic [2:0] neg_hi;
    } side_t;

    // Configuration registers.
    logic [2:0][CW-1:0]        origin_reg;
    logic [2:0][DIR_WIDTH-1:0] dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg[0] <= DIR_ONE;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_reg[0] <= cfg_data[CW-1:0];
                CFG_ORIGIN_Y: origin_reg[1] <= cfg_data[CW-1:0];
                CFG_ORIGIN_Z: origin_reg[2] <= cfg_data[CW-1:0];
                CFG_DIR_X:    dir_reg[0]    <= cfg_data[DIR_WIDTH-1:0];
                CFG_DIR_Y:    dir_reg[1]    <= cfg_data[DIR_WIDTH-1:0];
                CFG_DIR_Z:    dir_reg[2]    <= cfg_data[DIR_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline control: the whole pipeline moves together while the skid buffer is empty.
    logic               en;
    logic [NSTAGES-1:0] v_reg;
    logic               out_v_reg, skid_v_reg;
    result_t            out_reg, skid_reg, res_reg;
    logic               pop, push;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign pop      = out_v_reg && !out_stall;
    assign push     = en && v_reg[NSTAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[NSTAGES-2:0], in_valid};
            end
            if (skid_v_reg)
            begin
                if (pop)
                begin
                    skid_v_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_v_reg && !pop)
                begin
                    skid_v_reg <= 1'b1;
                end
                else
                begin
                    out_v_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !pop)
            begin
                skid_reg <= res_reg;
            end
            else
            begin
                out_reg <= res_reg;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Capture stage: offsets from the origin and the flat-direction slab check.
    logic [2:0][CW-1:0]        box_lo, box_hi, slab_mn, slab_mx;
    logic [2:0][DIFF_W-1:0]    diff_lo, diff_hi, num_lo_next, num_hi_next;
    logic [2:0][DIR_WIDTH-1:0] dir_mag;
    logic [2:0]                outside;
    side_t                     side_next;

    assign box_lo = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
    assign box_hi = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff_lo[a] = {box_lo[a][CW-1], box_lo[a]} - {origin_reg[a][CW-1], origin_reg[a]};
            diff_hi[a] = {box_hi[a][CW-1], box_hi[a]} - {origin_reg[a][CW-1], origin_reg[a]};
            num_lo_next[a] = diff_lo[a][DIFF_W-1] ? DIFF_W'(-diff_lo[a]) : diff_lo[a];
            num_hi_next[a] = diff_hi[a][DIFF_W-1] ? DIFF_W'(-diff_hi[a]) : diff_hi[a];
            dir_mag[a] = dir_reg[a][DIR_WIDTH-1] ? DIR_WIDTH'(~dir_reg[a] + 1'b1) : dir_reg[a];
            if ($signed(box_lo[a]) <= $signed(box_hi[a]))
            begin
                slab_mn[a] = box_lo[a];
                slab_mx[a] = box_hi[a];
            end
            else
            begin
                slab_mn[a] = box_hi[a];
                slab_mx[a] = box_lo[a];
            end
            side_next.dzero[a]  = (dir_reg[a] == '0);
            outside[a] = side_next.dzero[a]
                && (($signed(origin_reg[a]) < $signed(slab_mn[a]))
                    || ($signed(origin_reg[a]) > $signed(slab_mx[a])));
            side_next.neg_lo[a] = diff_lo[a][DIFF_W-1] ^ dir_reg[a][DIR_WIDTH-1];
            side_next.neg_hi[a] = diff_hi[a][DIFF_W-1] ^ dir_reg[a][DIR_WIDTH-1];
        end
        side_next.bx.lo = box_lo;
        side_next.bx.hi = box_hi;
        side_next.zmiss = |outside;
    end

    logic [2:0][DIFF_W-1:0] num_lo_reg, num_hi_reg;
    side_t                  side_reg [DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg  <= num_lo_next;
            num_hi_reg  <= num_hi_next;
            side_reg[0] <= side_next;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Slab distances: magnitudes of (corner - origin) * 2^30 / dir.
    logic [2:0][QUO_WIDTH-1:0] q_lo, q_hi;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbsi_div u_div_lo (
            .clk (clk),
            .en  (en),
            .num (num_lo_reg[a]),
            .den (dir_mag[a]),
            .quo (q_lo[a])
        );
        rbsi_div u_div_hi (
            .clk (clk),
            .en  (en),
            .num (num_hi_reg[a]),
            .den (dir_mag[a]),
            .quo (q_hi[a])
        );
    end

    // Near and far per axis; a flat direction leaves the axis unbounded.
    side_t              side_end;
    logic [2:0][CW-1:0] t_lo, t_hi, near_next, far_next;

    assign side_end = side_reg[DIV_STAGES];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            t_lo[a] = side_end.neg_lo[a] ? CW'(-{1'b0, q_lo[a]}) : {1'b0, q_lo[a]};
            t_hi[a] = side_end.neg_hi[a] ? CW'(-{1'b0, q_hi[a]}) : {1'b0, q_hi[a]};
            if (side_end.dzero[a])
            begin
                near_next[a] = NTMAX_C;
                far_next[a]  = TMAX_C;
            end
            else if ($signed(t_lo[a]) < $signed(t_hi[a]))
            begin
                near_next[a] = t_lo[a];
                far_next[a]  = t_hi[a];
            end
            else
            begin
                near_next[a] = t_hi[a];
                far_next[a]  = t_lo[a];
            end
        end
    end

    logic [2:0][CW-1:0] near_reg, far_reg;
    logic               nf_zmiss_reg;
    box_side_t          nf_bx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg     <= near_next;
            far_reg      <= far_next;
            nf_zmiss_reg <= side_end.zmiss;
            nf_bx_reg    <= side_end.bx;
        end
    end

    // Entry, exit and the chosen distance.
    logic [CW-1:0] tn, tf, sel_t_next;
    logic          sel_miss_next;

    always_comb
    begin
        tn = near_reg[0];
        if ($signed(near_reg[1]) > $signed(tn))
        begin
            tn = near_reg[1];
        end
        if ($signed(near_reg[2]) > $signed(tn))
        begin
            tn = near_reg[2];
        end
        tf = far_reg[0];
        if ($signed(far_reg[1]) < $signed(tf))
        begin
            tf = far_reg[1];
        end
        if ($signed(far_reg[2]) < $signed(tf))
        begin
            tf = far_reg[2];
        end
        sel_miss_next = nf_zmiss_reg || ($signed(tn) > $signed(tf)) || tf[CW-1];
        sel_t_next    = (!tn[CW-1] && (tn != '0)) ? tn : tf;
    end

    logic [CW-1:0] sel_t_reg;
    logic          sel_miss_reg;
    box_side_t     sel_bx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_t_reg    <= sel_t_next;
            sel_miss_reg <= sel_miss_next;
            sel_bx_reg   <= nf_bx_reg;
        end
    end

    // Hit point offset magnitudes |dir| * t; t is never negative on a hit.
    logic [2:0][PROD_W-1:0] prod_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_next[a] = PROD_W'(dir_mag[a]) * PROD_W'(sel_t_reg[QUO_WIDTH-1:0]);
        end
    end

    logic [2:0][PROD_W-1:0] mul_prod_reg;
    logic [CW-1:0]          mul_t_reg;
    logic                   mul_miss_reg;
    box_side_t              mul_bx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_prod_reg <= prod_next;
            mul_t_reg    <= sel_t_reg;
            mul_miss_reg <= sel_miss_reg;
            mul_bx_reg   <= sel_bx_reg;
        end
    end

    // Hit point, saturated to the coordinate range.
    logic [2:0][SUM_W-1:0] step_s, pt_sum;
    logic [2:0][CW-1:0]    pt_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            step_s[a] = SUM_W'(mul_prod_reg[a][PROD_W-1:DIR_FRAC]);
            if (dir_reg[a][DIR_WIDTH-1])
            begin
                step_s[a] = SUM_W'(-step_s[a]);
            end
            pt_sum[a] = {{(SUM_W-CW){origin_reg[a][CW-1]}}, origin_reg[a]} + step_s[a];
            if ($signed(pt_sum[a]) > $signed(SUM_W'(TMAX_C)))
            begin
                pt_next[a] = TMAX_C;
            end
            else if ($signed(pt_sum[a]) < $signed({{(SUM_W-CW){1'b1}}, CMIN_C}))
            begin
                pt_next[a] = CMIN_C;
            end
            else
            begin
                pt_next[a] = pt_sum[a][CW-1:0];
            end
        end
    end

    logic [2:0][CW-1:0] pt_reg;
    logic [CW-1:0]      pt_t_reg;
    logic               pt_miss_reg;
    box_side_t          pt_bx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg      <= pt_next;
            pt_t_reg    <= mul_t_reg;
            pt_miss_reg <= mul_miss_reg;
            pt_bx_reg   <= mul_bx_reg;
        end
    end

    // Local point (doubled) and box size on each axis, as magnitudes and signs.
    logic [2:0][SUM_W-1:0]  c2, p2;
    logic [2:0][DIFF_W-1:0] sz;
    logic [2:0][NUM_W-1:0]  num_next;
    logic [2:0][DEN_W-1:0]  den_next;
    logic [2:0]             c2neg_next, szneg_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p2[a] = {{(SUM_W-CW-1){pt_reg[a][CW-1]}}, pt_reg[a], 1'b0};
            c2[a] = p2[a]
                - {{(SUM_W-CW){pt_bx_reg.lo[a][CW-1]}}, pt_bx_reg.lo[a]}
                - {{(SUM_W-CW){pt_bx_reg.hi[a][CW-1]}}, pt_bx_reg.hi[a]};
            sz[a] = {pt_bx_reg.hi[a][CW-1], pt_bx_reg.hi[a]}
                - {pt_bx_reg.lo[a][CW-1], pt_bx_reg.lo[a]};
            c2neg_next[a] = c2[a][SUM_W-1];
            szneg_next[a] = sz[a][DIFF_W-1];
            num_next[a] = c2neg_next[a] ? NUM_W'(-c2[a]) : NUM_W'(c2[a]);
            if (num_next[a] == '0)
            begin
                den_next[a] = DEN_W'(1);
            end
            else
            begin
                den_next[a] = szneg_next[a] ? DEN_W'(-sz[a]) : DEN_W'(sz[a]);
            end
        end
    end

    logic [2:0][NUM_W-1:0] num_reg;
    logic [2:0][DEN_W-1:0] den_reg;
    logic [2:0]            c2neg_reg, szneg_reg;
    logic [2:0][CW-1:0]    num_pt_reg;
    logic [CW-1:0]         num_t_reg;
    logic                  num_miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg      <= num_next;
            den_reg      <= den_next;
            c2neg_reg    <= c2neg_next;
            szneg_reg    <= szneg_next;
            num_pt_reg   <= pt_reg;
            num_t_reg    <= pt_t_reg;
            num_miss_reg <= pt_miss_reg;
        end
    end

    // Ratios |local / size| are compared by cross multiplication.
    logic [XP_W-1:0] x01_next, x10_next, x02_next, x20_next, x12_next, x21_next;

    always_comb
    begin
        x01_next = XP_W'(num_reg[0]) * XP_W'(den_reg[1]);
        x10_next = XP_W'(num_reg[1]) * XP_W'(den_reg[0]);
        x02_next = XP_W'(num_reg[0]) * XP_W'(den_reg[2]);
        x20_next = XP_W'(num_reg[2]) * XP_W'(den_reg[0]);
        x12_next = XP_W'(num_reg[1]) * XP_W'(den_reg[2]);
        x21_next = XP_W'(num_reg[2]) * XP_W'(den_reg[1]);
    end

    logic [XP_W-1:0]    x01_reg, x10_reg, x02_reg, x20_reg, x12_reg, x21_reg;
    logic [2:0]         xp_c2neg_reg, xp_szneg_reg;
    logic [2:0][CW-1:0] xp_pt_reg;
    logic [CW-1:0]      xp_t_reg;
    logic               xp_miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x01_reg      <= x01_next;
            x10_reg      <= x10_next;
            x02_reg      <= x02_next;
            x20_reg      <= x20_next;
            x12_reg      <= x12_next;
            x21_reg      <= x21_next;
            xp_c2neg_reg <= c2neg_reg;
            xp_szneg_reg <= szneg_reg;
            xp_pt_reg    <= num_pt_reg;
            xp_t_reg     <= num_t_reg;
            xp_miss_reg  <= num_miss_reg;
        end
    end

    // Dominant axis, ties going to x and then y; a miss clears every field.
    logic [1:0] axis;
    logic       axis_neg;
    result_t    res_next;

    always_comb
    begin
        if ((x01_reg >= x10_reg) && (x02_reg >= x20_reg))
        begin
            axis = AXIS_X;
        end
        else if (x12_reg >= x21_reg)
        begin
            axis = AXIS_Y;
        end
        else
        begin
            axis = AXIS_Z;
        end
        case (axis)
            AXIS_X:  axis_neg = xp_c2neg_reg[0] ^ xp_szneg_reg[0];
            AXIS_Y:  axis_neg = xp_c2neg_reg[1] ^ xp_szneg_reg[1];
            AXIS_Z:  axis_neg = xp_c2neg_reg[2] ^ xp_szneg_reg[2];
            default: axis_neg = 1'b0;
        endcase
        if (xp_miss_reg)
        begin
            res_next = '0;
        end
        else
        begin
            res_next.hit             = 1'b1;
            res_next.distance        = xp_t_reg[CW-2:0];
            res_next.point_x         = xp_pt_reg[0];
            res_next.point_y         = xp_pt_reg[1];
            res_next.point_z         = xp_pt_reg[2];
            res_next.normal_axis     = axis;
            res_next.normal_negative = axis_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    `RBSI_ASSERT_IMP(a_miss_clear, clk, rst_n, out_valid && !out_data.hit, out_data.distance == '0 && out_data.point_x == '0 && out_data.normal_axis == AXIS_X)
    `RBSI_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg)
    `RBSI_ASSERT_NXT(a_wait_keeps, clk, rst_n, out_v_reg && out_stall, out_v_reg)
    `RBSI_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, v_reg[0])

endmodule

@@ tb/ray_box_slab_intersect_tb.sv @@
`timescale 1ns / 1ps
module ray_box_slab_intersect_tb;
    import rbsi_pkg::*;

    localparam longint TMAX     = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint CMIN     = -TMAX - 1;
    localparam longint FRAC_MSK = (longint'(1) << DIR_FRAC) - 1;
    localparam longint ONE_DIR  = longint'(1) << DIR_FRAC;
    localparam longint DIAG_DIR = 619925131;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = CFG_INDEX_WIDTH'(6);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_BOXES    = 210;

    class slab_scoreboard;
        longint org[3];
        longint dir[3];
        result_t pending[$];
        int errors;
        int hits;

        function new();
            org = '{0, 0, 0};
            dir = '{ONE_DIR, 0, 0};
            errors = 0;
            hits = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] v);
            case (idx)
                CFG_ORIGIN_X: org[0] = longint'($signed(v[COORD_WIDTH-1:0]));
                CFG_ORIGIN_Y: org[1] = longint'($signed(v[COORD_WIDTH-1:0]));
                CFG_ORIGIN_Z: org[2] = longint'($signed(v[COORD_WIDTH-1:0]));
                CFG_DIR_X:    dir[0] = longint'($signed(v[DIR_WIDTH-1:0]));
                CFG_DIR_Y:    dir[1] = longint'($signed(v[DIR_WIDTH-1:0]));
                CFG_DIR_Z:    dir[2] = longint'($signed(v[DIR_WIDTH-1:0]));
                default: ;
            endcase
        endfunction

        function longint unsigned magn(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // Slab distance in Q16.16, truncated towards zero and saturated.
        function longint slab_dist(longint diff, longint d);
            longint unsigned a, bm, q0, r, q;
            a = magn(diff);
            bm = magn(d);
            q0 = a / bm;
            r = a % bm;
            if (q0 > longint'(TMAX >> DIR_FRAC))
                q = TMAX;
            else
            begin
                q = (q0 << DIR_FRAC) + ((r << DIR_FRAC) / bm);
                if (q > longint'(TMAX))
                    q = TMAX;
            end
            return ((diff < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function longint scale_dir(longint d, longint t);
            longint unsigned a, bm, p;
            a = magn(d);
            bm = magn(t);
            p = a * (bm >> DIR_FRAC) + ((a * (bm & FRAC_MSK)) >> DIR_FRAC);
            return ((d < 0) != (t < 0)) ? -longint'(p) : longint'(p);
        endfunction

        function bit ratio_ge(longint unsigned a, longint unsigned b,
                              longint unsigned c, longint unsigned d);
            bit [127:0] lhs, rhs;
            lhs = 128'(a) * 128'(d);
            rhs = 128'(c) * 128'(b);
            return lhs >= rhs;
        endfunction

        function result_t predict(box_t bx);
            longint lo[3], hi[3], pt[3], c2[3], sz[3];
            longint unsigned num[3], den[3];
            longint tn, tf, t, t0, t1, a, b, p;
            bit miss;
            int ax;
            result_t r;
            lo = '{longint'($signed(bx.box_min_x)), longint'($signed(bx.box_min_y)),
                   longint'($signed(bx.box_min_z))};
            hi = '{longint'($signed(bx.box_max_x)), longint'($signed(bx.box_max_y)),
                   longint'($signed(bx.box_max_z))};
            r = '0;
            tn = -TMAX;
            tf = TMAX;
            miss = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (dir[i] == 0)
                begin
                    a = (lo[i] < hi[i]) ? lo[i] : hi[i];
                    b = (lo[i] < hi[i]) ? hi[i] : lo[i];
                    if (org[i] < a || org[i] > b)
                        miss = 1;
                end
                else
                begin
                    t0 = slab_dist(lo[i] - org[i], dir[i]);
                    t1 = slab_dist(hi[i] - org[i], dir[i]);
                    if (((t0 < t1) ? t0 : t1) > tn)
                        tn = (t0 < t1) ? t0 : t1;
                    if (((t0 < t1) ? t1 : t0) < tf)
                        tf = (t0 < t1) ? t1 : t0;
                end
            end
            if (miss || tn > tf || tf < 0)
                return r;
            t = (tn > 0) ? tn : tf;
            for (int i = 0; i < 3; i++)
            begin
                p = org[i] + scale_dir(dir[i], t);
                if (p > TMAX)
                    p = TMAX;
                if (p < CMIN)
                    p = CMIN;
                pt[i] = p;
                c2[i] = 2 * p - lo[i] - hi[i];
                sz[i] = hi[i] - lo[i];
                num[i] = magn(c2[i]);
                den[i] = (num[i] == 0) ? 1 : magn(sz[i]);
            end
            if (ratio_ge(num[0], den[0], num[1], den[1]) && ratio_ge(num[0], den[0], num[2], den[2]))
                ax = 0;
            else if (ratio_ge(num[1], den[1], num[2], den[2]))
                ax = 1;
            else
                ax = 2;
            r.hit = 1'b1;
            r.distance = t[COORD_WIDTH-2:0];
            r.point_x = pt[0][COORD_WIDTH-1:0];
            r.point_y = pt[1][COORD_WIDTH-1:0];
            r.point_z = pt[2][COORD_WIDTH-1:0];
            r.normal_axis = (ax == 0) ? AXIS_X : (ax == 1) ? AXIS_Y : AXIS_Z;
            r.normal_negative = (c2[ax] < 0) != (sz[ax] < 0);
            return r;
        endfunction

        function void note_box(box_t bx);
            pending.push_back(predict(bx));
        endfunction

        function void cmp(string fld, longint unsigned e, longint unsigned a);
            if (e != a)
            begin
                errors++;
                $display("%0t: %s expected %h, got %h", $time, fld, e, a);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.hit)
                hits++;
            cmp("hit", e.hit, got.hit);
            cmp("distance", e.distance, got.distance);
            cmp("point_x", e.point_x, got.point_x);
            cmp("point_y", e.point_y, got.point_y);
            cmp("point_z", e.point_z, got.point_z);
            cmp("normal_axis", e.normal_axis, got.normal_axis);
            cmp("normal_negative", e.normal_negative, got.normal_negative);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    box_t                       in_data;
    logic                       out_valid;
    logic                       out_stall;
    result_t                    out_data;

    slab_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int boxes_in;
    int results_out;
    int quiet_cycles;

    ray_box_slab_intersect u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_box(in_data);
                boxes_in++;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                results_out++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic coord_t units(longint n);
        return coord_t'(n <<< 16);
    endfunction

    function automatic box_t make_box(longint x0, longint y0, longint z0,
                                      longint x1, longint y1, longint z1);
        box_t b;
        b.box_min_x = units(x0);
        b.box_min_y = units(y0);
        b.box_min_z = units(z0);
        b.box_max_x = units(x1);
        b.box_max_y = units(y1);
        b.box_max_z = units(z1);
        return b;
    endfunction

    // Mostly boxes placed along the ray so that hits are common; the rest are
    // boxes round the origin or raw random bits.
    function automatic box_t rand_box();
        coord_t mn[3], mx[3], tmp;
        longint c, h, tt;
        int mode;
        box_t b;
        mode = $urandom_range(9);
        for (int i = 0; i < 3; i++)
        begin
            if (mode == 0)
            begin
                mn[i] = $urandom;
                mx[i] = $urandom;
            end
            else
            begin
                tt = (mode == 1) ? 0 : longint'($urandom_range(0, 150 << 16));
                c = sb.org[i] + ((sb.dir[i] * tt) >>> DIR_FRAC)
                    + longint'($urandom_range(0, 8 << 16)) - (4 << 16);
                h = $urandom_range(1, 1 << 22);
                if ($urandom_range(9) == 0)
                    h = 0;
                mn[i] = coord_t'(c - h);
                mx[i] = coord_t'(c + h);
                if ($urandom_range(7) == 0)
                begin
                    tmp = mn[i];
                    mn[i] = mx[i];
                    mx[i] = tmp;
                end
            end
        end
        b.box_min_x = mn[0];
        b.box_min_y = mn[1];
        b.box_min_z = mn[2];
        b.box_max_x = mx[0];
        b.box_max_y = mx[1];
        b.box_max_z = mx[2];
        return b;
    endfunction

    task automatic send_box(box_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The write enable is left high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_WIDTH'(v);
        sb.write_reg(idx, CFG_DATA_WIDTH'(v));
        @(posedge clk);
    endtask

    task automatic set_ray(longint ox, longint oy, longint oz,
                           longint dx, longint dy, longint dz);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        // The spare index must leave every register alone.
        write_reg(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic longint small_coord();
        return longint'($urandom_range(0, 200 << 16)) - (100 << 16);
    endfunction

    function automatic longint rand_dir();
        return longint'($urandom_range(0, 2 << DIR_FRAC)) - ONE_DIR;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        boxes_in = 0;
        results_out = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed boxes under the reset ray, which runs along +x from the origin.
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box('1);
        send_box('0);
        send_box(make_box(10, -1, -1, 20, 1, 1));
        send_box(make_box(20, 1, 1, 10, -1, -1));
        send_box(make_box(-20, -1, -1, -10, 1, 1));
        send_box(make_box(0, -1, -1, 5, 1, 1));
        send_box(make_box(5, -1, -1, 5, 1, 1));
        send_box(make_box(10, 2, -1, 20, 3, 1));
        send_box(make_box(10, 0, -1, 20, 0, 1));
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        send_box(make_box(32760, -1, -1, 32767, 1, 1));
        send_box(make_box(-32768, 0, 0, 32767, 0, 0));
        wait_drained();

        // With no direction at all only a box round the origin is a hit.
        set_ray(1 << 16, 2 << 16, 3 << 16, 0, 0, 0);
        send_box(make_box(0, 0, 0, 4, 4, 4));
        send_box(make_box(4, 4, 4, 0, 0, 0));
        send_box(make_box(1, 2, 3, 1, 2, 3));
        send_box(make_box(5, 0, 0, 9, 4, 4));
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_ray(small_coord(), small_coord(), small_coord(),
                           DIAG_DIR, DIAG_DIR, DIAG_DIR);
                1: set_ray(0, 0, 0, -ONE_DIR, 0, 0);
                2: set_ray(CMIN, TMAX, 0, 0, -ONE_DIR, ONE_DIR);
                3: set_ray(small_coord(), small_coord(), small_coord(),
                           rand_dir(), rand_dir(), rand_dir());
                4: set_ray(small_coord(), small_coord(), small_coord(), 0, 0, 0);
                5: set_ray(small_coord(), small_coord(), small_coord(),
                           -(longint'(1) << 31), (longint'(1) << 31) - 1, 1);
                6: set_ray(small_coord(), small_coord(), small_coord(), 0, 0, ONE_DIR);
                default: set_ray(small_coord(), small_coord(), small_coord(),
                                 -DIAG_DIR, DIAG_DIR, -DIAG_DIR);
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_BOXES; n++)
                send_box(rand_box());
            wait_drained();
        end

        $display("Sent %0d boxes across 10 ray settings, got %0d results, %0d of them hits.",
                 boxes_in, results_out, sb.hits);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
